/* rtl/core/vad_pkg.sv */
// vad_pkg: shared types, widths and the arctangent table for vector_angle_degrees.
// No dependencies; imported by every module of the block.
package vad_pkg;

    localparam int COORD_WIDTH_DEF     = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 8;
    localparam int CORDIC_STAGES_DEF   = 16;

    localparam int NORM_W   = 31;   // magnitudes after normalising shift
    localparam int SUMSQ_W  = 64;   // sum of three squared 31-bit values
    localparam int ROOT_N   = 32;   // square root digits, one per cell
    localparam int XY_W     = 38;   // CORDIC x/y, covers gain growth
    localparam int Z_W      = 27;   // CORDIC angle accumulator, 16 fraction bits
    localparam int Z_FRAC   = 16;
    localparam int TAB_LEN  = 32;

    localparam int ATAN_TAB [TAB_LEN] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0,
        0, 0, 0, 0, 0, 0, 0, 0
    };

    typedef enum logic [1:0] {
        OP_BETWEEN = 2'd0,
        OP_AXIS_X  = 2'd1,
        OP_AXIS_Y  = 2'd2,
        OP_AXIS_Z  = 2'd3
    } op_t;

    typedef struct packed {
        logic [SUMSQ_W-1:0] rem;
        logic [SUMSQ_W-1:0] root;
        logic [NORM_W-1:0]  dmag;
        logic               dneg;
        logic               zero;
    } sq_t;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   zero;
    } cd_t;

    function automatic logic signed [Z_W-1:0] atan_entry(input int idx);
        return Z_W'(ATAN_TAB[idx]);
    endfunction

endpackage

/* rtl/core/vad_front.sv */
// vad_front: products, dot/cross sums, normalising shift and squares (5 stages).
// Depends on vad_pkg.
module vad_front
    import vad_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    op,
    input  logic signed [COORD_WIDTH-1:0] a [3],
    input  logic signed [COORD_WIDTH-1:0] b [3],
    output logic                          out_valid,
    input  logic                          out_ready,
    output sq_t                           out_data
);
    localparam int PW  = 2 * COORD_WIDTH;
    localparam int SW  = PW + 2;
    localparam int SHW = $clog2(PW + 1);

    logic [4:0] v_reg;
    logic [4:0] ld;

    always_comb begin
        ld[4] = !v_reg[4] || out_ready;
        for (int k = 3; k >= 0; k--) begin
            ld[k] = !v_reg[k] || ld[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (ld[0]) v_reg[0] <= in_valid;
            for (int k = 1; k < 5; k++) begin
                if (ld[k]) v_reg[k] <= v_reg[k-1];
            end
        end
    end

    function automatic logic [PW-1:0] mag_sw(input logic signed [SW-1:0] v);
        logic [SW-1:0] t;
        t = v[SW-1] ? SW'(-v) : SW'(v);
        return t[PW-1:0];
    endfunction

    function automatic logic [NORM_W-1:0] shr_norm(input logic [PW-1:0] v,
                                                  input logic [SHW-1:0] sft);
        logic [PW+NORM_W-1:0] e;
        e = (PW + NORM_W)'(v) >> sft;
        return e[NORM_W-1:0];
    endfunction

    // stage 1: all nine products
    logic [1:0]                    op1_reg;
    logic                          zero1_reg;
    logic signed [COORD_WIDTH-1:0] a1_reg [3];
    logic signed [PW-1:0]          p1_reg [3];
    logic signed [PW-1:0]          q1_reg [3];
    logic signed [PW-1:0]          n1_reg [3];
    logic                          zero_in;

    assign zero_in = (a[0] == '0 && a[1] == '0 && a[2] == '0) ||
                     (op == OP_BETWEEN && b[0] == '0 && b[1] == '0 && b[2] == '0);

    always_ff @(posedge aclk) begin
        if (ld[0] && in_valid) begin
            op1_reg   <= op;
            zero1_reg <= zero_in;
            for (int k = 0; k < 3; k++) begin
                a1_reg[k] <= a[k];
                p1_reg[k] <= PW'(a[k]) * PW'(b[k]);
                q1_reg[k] <= PW'(a[(k+1)%3]) * PW'(b[(k+2)%3]);
                n1_reg[k] <= PW'(a[(k+2)%3]) * PW'(b[(k+1)%3]);
            end
        end
    end

    // stage 2: dot and cross magnitudes, or axis selection
    logic              zero2_reg, dneg2_reg;
    logic [PW-1:0]     dm2_reg;
    logic [PW-1:0]     cm2_reg [3];
    logic signed [SW-1:0] dot_s;
    logic              dneg_n;
    logic [PW-1:0]     dm_n;
    logic [PW-1:0]     cm_n [3];
    logic [1:0]        ax;

    always_comb begin
        dot_s  = SW'(p1_reg[0]) + SW'(p1_reg[1]) + SW'(p1_reg[2]);
        ax     = op1_reg - 2'd1;
        dneg_n = dot_s[SW-1];
        dm_n   = mag_sw(dot_s);
        for (int k = 0; k < 3; k++) begin
            cm_n[k] = mag_sw(SW'(q1_reg[k]) - SW'(n1_reg[k]));
        end
        if (op1_reg != OP_BETWEEN) begin
            dneg_n = a1_reg[ax][COORD_WIDTH-1];
            dm_n   = mag_sw(SW'(a1_reg[ax]));
            for (int k = 0; k < 3; k++) begin
                cm_n[k] = (2'(k) == ax) ? '0 : mag_sw(SW'(a1_reg[k]));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ld[1] && v_reg[0]) begin
            zero2_reg <= zero1_reg;
            dneg2_reg <= dneg_n;
            dm2_reg   <= dm_n;
            cm2_reg   <= cm_n;
        end
    end

    // stage 3: shift so the largest magnitude fits 31 bits
    logic [PW-1:0]     mx;
    logic [SHW-1:0]    sft;
    int                hb;
    logic              zero3_reg, dneg3_reg;
    logic [NORM_W-1:0] dm3_reg;
    logic [NORM_W-1:0] cm3_reg [3];

    always_comb begin
        mx = dm2_reg;
        for (int k = 0; k < 3; k++) begin
            if (cm2_reg[k] > mx) mx = cm2_reg[k];
        end
        hb = 0;
        for (int t = 0; t < PW; t++) begin
            if (mx[t]) hb = t;
        end
        sft = (hb >= NORM_W) ? SHW'(hb - NORM_W + 1) : '0;
    end

    always_ff @(posedge aclk) begin
        if (ld[2] && v_reg[1]) begin
            zero3_reg <= zero2_reg;
            dneg3_reg <= dneg2_reg;
            dm3_reg   <= shr_norm(dm2_reg, sft);
            for (int k = 0; k < 3; k++) cm3_reg[k] <= shr_norm(cm2_reg[k], sft);
        end
    end

    // stage 4: squares
    logic                  zero4_reg, dneg4_reg;
    logic [NORM_W-1:0]     dm4_reg;
    logic [2*NORM_W-1:0]   sq4_reg [3];

    always_ff @(posedge aclk) begin
        if (ld[3] && v_reg[2]) begin
            zero4_reg <= zero3_reg;
            dneg4_reg <= dneg3_reg;
            dm4_reg   <= dm3_reg;
            for (int k = 0; k < 3; k++) begin
                sq4_reg[k] <= (2*NORM_W)'(cm3_reg[k]) * (2*NORM_W)'(cm3_reg[k]);
            end
        end
    end

    // stage 5: sum of squares
    sq_t out_reg;

    always_ff @(posedge aclk) begin
        if (ld[4] && v_reg[3]) begin
            out_reg.rem  <= SUMSQ_W'(sq4_reg[0]) + SUMSQ_W'(sq4_reg[1]) +
                            SUMSQ_W'(sq4_reg[2]);
            out_reg.root <= '0;
            out_reg.dmag <= dm4_reg;
            out_reg.dneg <= dneg4_reg;
            out_reg.zero <= zero4_reg;
        end
    end

    assign in_ready  = ld[0];
    assign out_valid = v_reg[4];
    assign out_data  = out_reg;

endmodule

/* rtl/core/vad_sqrt_cell.sv */
// vad_sqrt_cell: one digit of the integer square root of the sum of squares.
// Depends on vad_pkg.
module vad_sqrt_cell
    import vad_pkg::*;
#(
    parameter int BIT_POS = 0
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  sq_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output sq_t  out_data
);
    localparam logic [SUMSQ_W-1:0] BIT = SUMSQ_W'(1) << (2 * BIT_POS);

    logic v_reg;
    sq_t  d_reg, d_next;
    logic [SUMSQ_W-1:0] trial;

    assign in_ready = !v_reg || out_ready;

    always_comb begin
        d_next = in_data;
        trial  = in_data.root + BIT;
        if (in_data.rem >= trial) begin
            d_next.rem  = in_data.rem - trial;
            d_next.root = (in_data.root >> 1) + BIT;
        end else begin
            d_next.root = in_data.root >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (in_ready) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) d_reg <= d_next;
    end

    assign out_valid = v_reg;
    assign out_data  = d_reg;

endmodule

/* rtl/core/vad_cordic_cell.sv */
// vad_cordic_cell: one vectoring CORDIC rotation, fixed shift and table angle.
// Depends on vad_pkg.
module vad_cordic_cell
    import vad_pkg::*;
#(
    parameter int STAGE = 0
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  cd_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output cd_t  out_data
);
    localparam logic signed [Z_W-1:0] ANG = atan_entry(STAGE);

    logic v_reg;
    cd_t  d_reg, d_next;
    logic signed [XY_W-1:0] dx, dy;

    assign in_ready = !v_reg || out_ready;

    always_comb begin
        dx = in_data.y >>> STAGE;
        dy = in_data.x >>> STAGE;
        d_next = in_data;
        if (!in_data.y[XY_W-1]) begin
            d_next.x = in_data.x + dx;
            d_next.y = in_data.y - dy;
            d_next.z = in_data.z + ANG;
        end else begin
            d_next.x = in_data.x - dx;
            d_next.y = in_data.y + dy;
            d_next.z = in_data.z - ANG;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (in_ready) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) d_reg <= d_next;
    end

    assign out_valid = v_reg;
    assign out_data  = d_reg;

endmodule

/* rtl/core/vector_angle_degrees.sv */
// vector_angle_degrees: top level, angle of two 3D vectors or of one vector to an axis.
// Depends on vad_pkg, vad_front, vad_sqrt_cell, vad_cordic_cell.
//
// Input channel s_*: one transaction carries vectors a and b in tdata and the op
// in tuser. Op 0 gives the angle between a and b; ops 1..3 the angle of a to the
// X, Y or Z axis (b unused). Output channel m_*: tdata is the angle in unsigned
// degrees with ANGLE_FRAC_BITS fraction bits, tuser flags a zero-length vector
// (angle then 0). Exactly one output transaction per input transaction, in order.
// Pipeline: 5 front stages for products, sums, normalising shift and squares,
// 32 square-root digit cells, CORDIC_STAGES rotation cells, one output register.
// Throughput: one transaction per cycle while m_tready is high.
// Every cell holds one transaction with its own valid bit; a cell loads when it
// is empty or its successor moves, so bubbles collapse and s_tready stays high
// while any cell of the chain has room, also while m_tdata waits to be taken.
// When m_tready is low the chain fills and s_tready drops once every cell is full.
// Reset (aresetn low, synchronous) empties every cell; payload is not cleared.
module vector_angle_degrees
    import vad_pkg::*;
#(
    parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z (COORD_WIDTH each) from bit 0 up, zero filled
    input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]    s_tdata,
    // op
    input  logic [1:0]                            s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // angle_deg
    output logic [15:0]                           m_tdata,
    // zero_length
    output logic                                  m_tuser
);
    localparam int CW       = COORD_WIDTH;
    localparam int SH       = Z_FRAC - ANGLE_FRAC_BITS;
    localparam int RND      = (SH > 0) ? (1 << (SH - 1)) : 0;
    localparam int Z_MAX    = 180 << Z_FRAC;
    localparam int A_MAX_F  = 180 << ANGLE_FRAC_BITS;
    localparam logic [15:0] A_MAX = (A_MAX_F > 65535) ? 16'hFFFF : 16'(A_MAX_F);

    logic signed [CW-1:0] a_in [3];
    logic signed [CW-1:0] b_in [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            a_in[k] = s_tdata[k*CW +: CW];
            b_in[k] = s_tdata[(k+3)*CW +: CW];
        end
    end

    // front pipeline -> square root chain
    logic sq_v   [ROOT_N+1];
    logic sq_rdy [ROOT_N+1];
    sq_t  sq_d   [ROOT_N+1];

    vad_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .op        (s_tuser),
        .a         (a_in),
        .b         (b_in),
        .out_valid (sq_v[0]),
        .out_ready (sq_rdy[0]),
        .out_data  (sq_d[0])
    );

    // digit cells from the top digit down
    for (genvar j = 0; j < ROOT_N; j++) begin : g_sqrt
        vad_sqrt_cell #(
            .BIT_POS (ROOT_N - 1 - j)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (sq_v[j]),
            .in_ready  (sq_rdy[j]),
            .in_data   (sq_d[j]),
            .out_valid (sq_v[j+1]),
            .out_ready (sq_rdy[j+1]),
            .out_data  (sq_d[j+1])
        );
    end

    // CORDIC start: dot in the right half plane, else pre-rotate by 90 degrees
    logic cd_v   [CORDIC_STAGES+1];
    logic cd_rdy [CORDIC_STAGES+1];
    cd_t  cd_d   [CORDIC_STAGES+1];
    logic signed [XY_W-1:0] root_x, dmag_x;

    assign root_x = XY_W'(sq_d[ROOT_N].root[ROOT_N-1:0]);
    assign dmag_x = XY_W'(sq_d[ROOT_N].dmag);

    always_comb begin
        cd_d[0].zero = sq_d[ROOT_N].zero;
        if (!sq_d[ROOT_N].dneg) begin
            cd_d[0].x = dmag_x;
            cd_d[0].y = root_x;
            cd_d[0].z = '0;
        end else begin
            cd_d[0].x = root_x;
            cd_d[0].y = dmag_x;
            cd_d[0].z = Z_W'(90 << Z_FRAC);
        end
    end

    assign cd_v[0]        = sq_v[ROOT_N];
    assign sq_rdy[ROOT_N] = cd_rdy[0];

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
        vad_cordic_cell #(
            .STAGE (i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (cd_v[i]),
            .in_ready  (cd_rdy[i]),
            .in_data   (cd_d[i]),
            .out_valid (cd_v[i+1]),
            .out_ready (cd_rdy[i+1]),
            .out_data  (cd_d[i+1])
        );
    end

    // clamp to 0..180, round half up, saturate to 16 bits; a zero-length vector gives 0
    logic             out_v_reg;
    logic [15:0]      angle_reg, angle_next;
    logic             zl_reg;
    logic [Z_W-1:0]   zc;
    logic [Z_W:0]     zr;
    cd_t              fin;

    assign fin = cd_d[CORDIC_STAGES];
    assign cd_rdy[CORDIC_STAGES] = !out_v_reg || m_tready;

    always_comb begin
        if (fin.z[Z_W-1]) begin
            zc = '0;
        end else if (fin.z > Z_W'(Z_MAX)) begin
            zc = Z_W'(Z_MAX);
        end else begin
            zc = fin.z;
        end
        zr = ((Z_W+1)'(zc) + (Z_W+1)'(RND)) >> SH;
        angle_next = (zr > (Z_W+1)'(16'hFFFF)) ? 16'hFFFF : zr[15:0];
        if (fin.zero) angle_next = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (cd_rdy[CORDIC_STAGES]) begin
            out_v_reg <= cd_v[CORDIC_STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (cd_rdy[CORDIC_STAGES] && cd_v[CORDIC_STAGES]) begin
            angle_reg <= angle_next;
            zl_reg    <= fin.zero;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = angle_reg;
    assign m_tuser  = zl_reg;

    // zero-length result always carries angle 0
    a_zero_angle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == 16'd0)
        else $error("zero-length transaction with nonzero angle");

    // angle never beyond 180 degrees in the output format
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata <= A_MAX)
        else $error("angle above 180 degrees");

    // input stalls only when the whole chain is full and the output is held
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled while output side can move");

endmodule
